FILE: sv/assert_macros.svh
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: sv/cdtb_pkg.sv
// ----------------------------------------------------------------------------
// cdtb_pkg
// Shared types, constants and the display conversion for the countdown
// timer bank.
// ----------------------------------------------------------------------------
package cdtb_pkg;

  localparam int ROWS_DEF     = 4;
  localparam int SLOTS_DEF    = 4;
  localparam int RESULT_LIMIT = 16;
  localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

  localparam int CMD_W   = 2;
  localparam int IDX2_W  = 2;
  localparam int SEC_W   = 16;
  localparam int SHOWN_W = 8;

  localparam logic signed [SEC_W-1:0]   SEC_BLANK   = -16'sd1;
  localparam logic signed [SEC_W-1:0]   SEC_MINUTE  = 16'sd60;
  localparam logic signed [SEC_W-1:0]   SEC_CAP     = 16'sd5940;
  localparam logic signed [SHOWN_W-1:0] SHOWN_BLANK = -8'sd1;
  localparam logic signed [SHOWN_W-1:0] SHOWN_CAP   = 8'sd99;

  // floor(x / 60) as (x * RECIP) >> RECIP_SH, exact for x below 5941
  localparam int          QUO_W    = 13;
  localparam int          RECIP_SH = 20;
  localparam int          PROD_W   = 28;
  localparam logic [14:0] RECIP    = 15'd17477;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_SET     = 2'd1,
    CMD_REFRESH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FLUSH
  } state_t;

  function automatic logic signed [SHOWN_W-1:0] display_of(
    input logic signed [SEC_W-1:0] secs
  );
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(secs[QUO_W-1:0]) * PROD_W'(RECIP);
    if (secs < 16'sd0) begin
      return SHOWN_BLANK;
    end else if (secs < SEC_MINUTE) begin
      return secs[SHOWN_W-1:0];
    end else if (secs > SEC_CAP) begin
      return SHOWN_CAP;
    end else begin
      return prod[PROD_W-1:RECIP_SH];
    end
  endfunction

endpackage

FILE: sv/cdtb_if.sv
// ----------------------------------------------------------------------------
// cdtb_if
// Valid/ready channels of the countdown timer bank: command channel and
// display update channel.
// ----------------------------------------------------------------------------
interface cdtb_in_if import cdtb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [IDX2_W-1:0]        row_index;
  logic [IDX2_W-1:0]        slot_index;
  logic signed [SEC_W-1:0]  seconds_value;

  modport source (output valid, command, row_index, slot_index, seconds_value,
                  input ready);
  modport sink   (input valid, command, row_index, slot_index, seconds_value,
                  output ready);
endinterface

interface cdtb_out_if import cdtb_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [IDX2_W-1:0]         out_row;
  logic [IDX2_W-1:0]         out_slot;
  logic signed [SHOWN_W-1:0] shown_value;
  logic                      last_of_run;

  modport source (output valid, out_row, out_slot, shown_value, last_of_run,
                  input ready);
  modport sink   (input valid, out_row, out_slot, shown_value, last_of_run,
                  output ready);
endinterface

FILE: sv/countdown_timer_bank_display.sv
// ----------------------------------------------------------------------------
// countdown_timer_bank_display
// Bank of ROWS x SLOTS_PER_ROW countdown timers feeding a departure display.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries commands: tick (lower every positive timer by one), set
//   (write one timer) and refresh (report every timer). out_chan carries one
//   display update per transaction: row, slot, shown value and a flag on the
//   final update caused by a command. Unused command codes are dropped.
//   A set's update goes from the pending register to the output register. A tick
//   or refresh walks the timer memory one entry per cycle while out_chan keeps
//   up, and in_chan is not ready again until the walk and its final update are
//   done; the walk rate is set by the single read port of the timer memory and
//   the one shared display conversion unit.
//   Each update is held back by one entry so the final one can be flagged;
//   at most 16 updates are reported per command.
//   Reset (synchronous) blanks every timer at once through per-entry valid
//   bits. When out_chan stalls, the walk pauses on the next reportable
//   timer; the output register frees in_chan from out_chan otherwise.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module countdown_timer_bank_display import cdtb_pkg::*; #(
  parameter int ROWS          = ROWS_DEF,
  parameter int SLOTS_PER_ROW = SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cdtb_in_if.sink    in_chan,
  cdtb_out_if.source out_chan
);

  localparam int COUNT  = ROWS * SLOTS_PER_ROW;
  localparam int IDX_W  = (COUNT > 1) ? $clog2(COUNT) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
  localparam int ADDR_CALC_W = 9;

  // timer memory and its valid bits
  logic signed [SEC_W-1:0] mem [COUNT];
  logic [COUNT-1:0]        vld_r;

  state_t                    state_r, state_nxt;
  logic [CMD_W-1:0]          cmd_r;
  logic [IDX_W-1:0]          idx_r;
  logic [ROW_W-1:0]          row_r;
  logic [SLOT_W-1:0]         slot_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [SEC_W-1:0]   rd_data_r;
  logic                      rd_vld_r;

  logic                      pend_valid_r;
  logic [IDX2_W-1:0]         pend_row_r;
  logic [IDX2_W-1:0]         pend_slot_r;
  logic signed [SHOWN_W-1:0] pend_shown_r;

  logic                      out_valid_r;
  logic [IDX2_W-1:0]         out_row_r;
  logic [IDX2_W-1:0]         out_slot_r;
  logic signed [SHOWN_W-1:0] out_shown_r;
  logic                      out_last_r;

  logic                      in_fire;
  logic                      set_ok;
  logic [ADDR_CALC_W-1:0]    set_addr_full;
  logic [IDX_W-1:0]          set_addr;
  logic signed [SEC_W-1:0]   entry;
  logic signed [SEC_W-1:0]   dec;
  logic                      is_tick;
  logic                      report;
  logic                      take;
  logic                      out_free;
  logic                      last_idx;
  logic signed [SEC_W-1:0]   unit_in;
  logic signed [SHOWN_W-1:0] shown_res;

  // sequencer controls
  logic                      start_set;
  logic                      start_sweep;
  logic                      advance;
  logic                      pend_load;
  logic                      push;
  logic                      push_last;
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic signed [SEC_W-1:0]   wr_data;
  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;

  assign in_fire = in_chan.valid & in_chan.ready;
  assign set_ok  = (5'(in_chan.row_index) < 5'(ROWS))
                && (5'(in_chan.slot_index) < 5'(SLOTS_PER_ROW));
  assign set_addr_full = ADDR_CALC_W'(in_chan.row_index) * ADDR_CALC_W'(SLOTS_PER_ROW)
                       + ADDR_CALC_W'(in_chan.slot_index);
  assign set_addr = set_addr_full[IDX_W-1:0];

  // a never-written entry reads as blank
  assign entry    = rd_vld_r ? rd_data_r : SEC_BLANK;
  assign dec      = entry - 16'sd1;
  assign is_tick  = (cmd_r == CMD_TICK);
  assign report   = is_tick ? (entry > 16'sd0) : 1'b1;
  assign take     = report && (cnt_r < CNT_W'(RESULT_LIMIT));
  assign out_free = !out_valid_r || out_chan.ready;
  assign last_idx = (idx_r == IDX_W'(COUNT - 1));

  // shared display conversion unit
  assign unit_in   = (state_r == ST_IDLE) ? in_chan.seconds_value
                   : (is_tick ? dec : entry);
  assign shown_res = display_of(unit_in);

  always_comb begin
    state_nxt   = state_r;
    start_set   = 1'b0;
    start_sweep = 1'b0;
    advance     = 1'b0;
    pend_load   = 1'b0;
    push        = 1'b0;
    push_last   = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    wr_data     = dec;
    rd_en       = 1'b0;
    rd_addr     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          priority case (in_chan.command)
            CMD_SET: begin
              start_set = set_ok;
              wr_en     = set_ok;
              wr_addr   = set_addr;
              wr_data   = in_chan.seconds_value;
              state_nxt = ST_FLUSH;
            end
            CMD_TICK, CMD_REFRESH: begin
              start_sweep = 1'b1;
              rd_en       = 1'b1;
              state_nxt   = ST_SWEEP;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        // hold on a reportable entry while the previous one cannot leave
        advance   = !(take && pend_valid_r && !out_free);
        pend_load = advance && take;
        push      = pend_load && pend_valid_r;
        wr_en     = advance && is_tick && (entry > 16'sd0);
        if (advance) begin
          if (last_idx) begin
            state_nxt = ST_FLUSH;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r + IDX_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      vld_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      idx_r        <= '0;
      row_r        <= '0;
      slot_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (start_sweep) begin
        idx_r  <= '0;
        row_r  <= '0;
        slot_r <= '0;
        cnt_r  <= '0;
      end else if (advance) begin
        idx_r <= idx_r + IDX_W'(1);
        if (slot_r == SLOT_W'(SLOTS_PER_ROW - 1)) begin
          slot_r <= '0;
          row_r  <= row_r + ROW_W'(1);
        end else begin
          slot_r <= slot_r + SLOT_W'(1);
        end
        if (pend_load) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (start_set || pend_load) begin
        pend_valid_r <= 1'b1;
      end else if (push_last) begin
        pend_valid_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_chan.command;
    end
    if (start_set) begin
      pend_row_r   <= in_chan.row_index;
      pend_slot_r  <= in_chan.slot_index;
      pend_shown_r <= shown_res;
    end else if (pend_load) begin
      pend_row_r   <= IDX2_W'(row_r);
      pend_slot_r  <= IDX2_W'(slot_r);
      pend_shown_r <= shown_res;
    end
    if (push) begin
      out_row_r   <= pend_row_r;
      out_slot_r  <= pend_slot_r;
      out_shown_r <= pend_shown_r;
      out_last_r  <= push_last;
    end
  end

  // timer memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  assign in_chan.ready        = (state_r == ST_IDLE);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_row     = out_row_r;
  assign out_chan.out_slot    = out_slot_r;
  assign out_chan.shown_value = out_shown_r;
  assign out_chan.last_of_run = out_last_r;

  `ASSERT_NEVER(a_idle_no_pending, (state_r == ST_IDLE) && pend_valid_r, "update left pending while idle")
  `ASSERT_NEVER(a_cnt_limit, cnt_r > CNT_W'(RESULT_LIMIT), "update count beyond limit")
  `ASSERT_CLK(a_last_ends_run, push_last |=> (state_r == ST_IDLE), "final update did not end the command")
  `ASSERT_CLK(a_stall_only_on_busy_out, ((state_r == ST_SWEEP) && !advance) |-> (out_valid_r && !out_chan.ready), "walk paused with a free output register")

endmodule

FILE: tb/tb_countdown_timer_bank_display.sv
// ----------------------------------------------------------------------------
// tb_countdown_timer_bank_display
// Self-checking bench for the countdown timer bank. Commands are fed from a
// queue by a clocked driver; a shadow copy of the sixteen timers works out
// the display updates each accepted command should produce, and a clocked
// monitor compares every update against the oldest one still awaited.
// ----------------------------------------------------------------------------
module tb_countdown_timer_bank_display;
  import cdtb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
  localparam int               TIMER_COUNT = ROWS_DEF * SLOTS_DEF;
  localparam int               PHASE_ITEMS = 112;
  localparam int               LONG_HOLD   = 240;

  typedef struct {
    logic [CMD_W-1:0]         command;
    logic [IDX2_W-1:0]        row;
    logic [IDX2_W-1:0]        slot;
    logic signed [SEC_W-1:0]  secs;
  } timer_cmd_t;

  typedef struct {
    logic [IDX2_W-1:0]         row;
    logic [IDX2_W-1:0]         slot;
    logic signed [SHOWN_W-1:0] shown;
    logic                      last_of_run;
  } display_update_t;

  logic clk;
  logic rst_n;

  cdtb_in_if  in_if ();
  cdtb_out_if out_if ();

  countdown_timer_bank_display dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  timer_cmd_t              command_queue[$];
  display_update_t         pending_updates[$];
  logic signed [SEC_W-1:0] timer_copy [TIMER_COUNT];
  timer_cmd_t              current_cmd = '{default: '0};
  bit                      offering;
  int                      sender_idle_pct;
  int                      receiver_idle_pct;
  bit                      hold_request;
  bit                      hold_done;
  int                      hold_left;
  int                      mismatches;
  int                      updates_checked;
  int                      tick_count, set_count, refresh_count, unused_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAIL countdown_timer_bank_display");
    $finish;
  end

  function automatic logic signed [SHOWN_W-1:0] shown_of(
    input logic signed [SEC_W-1:0] secs
  );
    int s;
    s = secs;
    if (s < 0) return SHOWN_BLANK;
    if (s < 60) return SHOWN_W'(s);
    if (s > 99 * 60) return SHOWN_CAP;
    return SHOWN_W'(s / 60);
  endfunction

  // updates the shadow timers and queues the display updates of one command
  function automatic void compute_display_updates(input timer_cmd_t c);
    int                      idx;
    int                      produced;
    display_update_t         u;
    logic signed [SEC_W-1:0] v;
    produced = 0;
    if (c.command == CMD_SET) begin
      set_count++;
      idx = c.row * SLOTS_DEF + c.slot;
      timer_copy[idx] = c.secs;
      u.row = c.row;
      u.slot = c.slot;
      u.shown = shown_of(c.secs);
      u.last_of_run = 1'b1;
      pending_updates.push_back(u);
    end else if (c.command == CMD_TICK || c.command == CMD_REFRESH) begin
      if (c.command == CMD_TICK) tick_count++;
      else refresh_count++;
      for (idx = 0; idx < TIMER_COUNT; idx++) begin
        v = timer_copy[idx];
        if (c.command == CMD_REFRESH || v > 0) begin
          if (c.command == CMD_TICK) begin
            v = v - 1;
            timer_copy[idx] = v;
          end
          if (produced < RESULT_LIMIT) begin
            u.row = IDX2_W'(idx / SLOTS_DEF);
            u.slot = IDX2_W'(idx % SLOTS_DEF);
            u.shown = shown_of(v);
            u.last_of_run = 1'b0;
            pending_updates.push_back(u);
            produced++;
          end
        end
      end
      if (produced != 0) pending_updates[pending_updates.size() - 1].last_of_run = 1'b1;
    end else begin
      unused_count++;
    end
  endfunction

  function automatic void queue_command(input logic [CMD_W-1:0] command,
                                        input int row, input int slot,
                                        input int secs);
    timer_cmd_t c;
    c.command = command;
    c.row = IDX2_W'(row);
    c.slot = IDX2_W'(slot);
    c.secs = SEC_W'(secs);
    command_queue.push_back(c);
  endfunction

  // mostly values that tick through the interesting boundaries
  function automatic logic signed [SEC_W-1:0] random_seconds();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) return SEC_W'($urandom_range(6));
    if (pick < 60) return SEC_W'($urandom_range(130, 50));
    if (pick < 70) return SEC_W'($urandom_range(5950, 5930));
    if (pick < 77) return SEC_W'($urandom_range(3610, 3590));
    if (pick < 85) return SEC_W'(-int'($urandom_range(32768, 1)));
    return SEC_W'($urandom);
  endfunction

  function automatic timer_cmd_t random_command();
    timer_cmd_t c;
    int         pick;
    c.row = IDX2_W'($urandom_range(3));
    c.slot = IDX2_W'($urandom_range(3));
    c.secs = SEC_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 38) begin
      c.command = CMD_TICK;
    end else if (pick < 80) begin
      c.command = CMD_SET;
      c.secs = random_seconds();
    end else if (pick < 93) begin
      c.command = CMD_REFRESH;
    end else begin
      c.command = CMD_UNUSED;
    end
    return c;
  endfunction

  task automatic drain_commands();
    while (command_queue.size() != 0 || offering) @(posedge clk);
  endtask

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      offering = 1'b0;
      in_if.valid <= 1'b0;
    end else begin
      if (offering && in_if.ready) begin
        compute_display_updates(current_cmd);
        offering = 1'b0;
      end
      if (!offering && command_queue.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        current_cmd = command_queue.pop_front();
        offering = 1'b1;
      end
      in_if.valid         <= offering;
      in_if.command       <= current_cmd.command;
      in_if.row_index     <= current_cmd.row;
      in_if.slot_index    <= current_cmd.slot;
      in_if.seconds_value <= current_cmd.secs;
    end
  end

  always @(posedge clk) begin : monitor
    display_update_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        updates_checked++;
        if (pending_updates.size() == 0) begin
          $display("%0t: unexpected update row %0d slot %0d shown %0d last %0b", $time,
                   out_if.out_row, out_if.out_slot, out_if.shown_value,
                   out_if.last_of_run);
          mismatches++;
        end else begin
          want = pending_updates.pop_front();
          if (out_if.out_row !== want.row || out_if.out_slot !== want.slot ||
              out_if.shown_value !== want.shown ||
              out_if.last_of_run !== want.last_of_run) begin
            $display("%0t: expected row %0d slot %0d shown %0d last %0b, got row %0d slot %0d shown %0d last %0b",
                     $time, want.row, want.slot, want.shown, want.last_of_run,
                     out_if.out_row, out_if.out_slot, out_if.shown_value,
                     out_if.last_of_run);
            mismatches++;
          end
        end
      end
      // long hold-off so the bank backs up and stalls its command channel
      if (hold_request && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int i;
    in_if.valid         = 1'b0;
    in_if.command       = CMD_TICK;
    in_if.row_index     = '0;
    in_if.slot_index    = '0;
    in_if.seconds_value = '0;
    out_if.ready        = 1'b0;
    rst_n               = 1'b0;
    sender_idle_pct     = 14;
    receiver_idle_pct   = 54;
    for (i = 0; i < TIMER_COUNT; i++) timer_copy[i] = SEC_BLANK;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // blank bank, then the display boundaries
    queue_command(CMD_REFRESH, 0, 0, 0);
    queue_command(CMD_TICK, 0, 0, 0);
    queue_command(CMD_SET, 0, 0, 32767);
    queue_command(CMD_SET, 3, 3, -32768);
    queue_command(CMD_SET, 1, 2, 0);
    queue_command(CMD_SET, 2, 1, 59);
    queue_command(CMD_SET, 0, 3, 60);
    queue_command(CMD_SET, 3, 0, 5940);
    queue_command(CMD_SET, 1, 1, 5941);
    queue_command(CMD_SET, 2, 2, 120);
    queue_command(CMD_SET, 0, 1, 1);
    queue_command(CMD_SET, 3, 2, -1);
    queue_command(CMD_UNUSED, 3, 3, 32767);
    queue_command(CMD_TICK, 0, 0, 0);
    // the timer set to one reached zero on the last tick, so this tick no longer reports it
    queue_command(CMD_TICK, 0, 0, 0);
    queue_command(CMD_REFRESH, 0, 0, 0);
    queue_command(CMD_SET, 1, 2, -1);
    queue_command(CMD_SET, 2, 3, 21845);
    queue_command(CMD_UNUSED, 0, 0, -32768);
    queue_command(CMD_REFRESH, 0, 0, 0);

    for (i = 0; i < PHASE_ITEMS; i++) command_queue.push_back(random_command());
    drain_commands();

    sender_idle_pct   = 54;
    receiver_idle_pct = 14;
    for (i = 0; i < PHASE_ITEMS; i++) command_queue.push_back(random_command());
    drain_commands();

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    for (i = 0; i < PHASE_ITEMS; i++) command_queue.push_back(random_command());
    hold_request = 1'b1;
    drain_commands();

    while (pending_updates.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d commands: %0d tick, %0d set, %0d refresh, %0d unused code",
             tick_count + set_count + refresh_count + unused_count,
             tick_count, set_count, refresh_count, unused_count);
    $display("checked %0d display updates, %0d mismatches", updates_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS countdown_timer_bank_display");
    end else begin
      $display("FAIL countdown_timer_bank_display");
    end
    $finish;
  end

endmodule

FILE: countdown_timer_bank_display.f
+incdir+sv
sv/cdtb_pkg.sv
sv/cdtb_if.sv
sv/countdown_timer_bank_display.sv
tb/tb_countdown_timer_bank_display.sv
